// ===== src/saturating_integer_alu_top_assert.svh =====
// Assertion macros for the saturating integer ALU top level.
// Depends on nothing; the using module must have clk_i and rst_ni.
`ifndef SATURATING_INTEGER_ALU_TOP_ASSERT_SVH
`define SATURATING_INTEGER_ALU_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SIAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SIAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SIAL_ASSERT_IMP(lbl, ante, cons, msg)
`define SIAL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/sial_pkg.sv =====
// Package of the saturating integer ALU: beat types, operation codes,
// constants and the clamping helpers. Depends on nothing.
package sial_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned Steps  = DataW;
  localparam int unsigned StepW  = $clog2(Steps);

  localparam logic [DataW-1:0] SMax   = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] SMin   = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] PowCap = {1'b1, {(DataW-2){1'b0}}, 1'b1};

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_EQ  = 4'd4,
    OP_LT  = 4'd5,
    OP_GT  = 4'd6,
    OP_MOD = 4'd7,
    OP_POW = 4'd8,
    OP_AND = 4'd9,
    OP_OR  = 4'd10
  } mode_e;

  typedef struct packed {
    logic [3:0]              mode;
    logic signed [DataW-1:0] left;
    logic signed [DataW-1:0] right;
  } in_beat_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    error;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic div;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Applies a sign to a magnitude {hi, lo} and clamps to the signed range.
  function automatic logic [DataW-1:0] sat_clamp(logic hi_nz, logic [DataW-1:0] lo,
                                                 logic neg);
    logic big;
    big = hi_nz | lo[DataW-1];
    if (neg) begin
      return big ? SMin : (~lo + 1'b1);
    end
    return big ? SMax : lo;
  endfunction

  // Unsigned product {hi, lo} limited to the power cap.
  function automatic logic [DataW-1:0] cap_prod(logic [DataW-1:0] hi, logic [DataW-1:0] lo);
    return ((hi != '0) || (lo > PowCap)) ? PowCap : lo;
  endfunction

endpackage

// ===== src/sial_unit.sv =====
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// Depends on sial_pkg.
module sial_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sial_pkg::unit_ctl_t             ctl_i,
  input  logic [sial_pkg::DataW-1:0]      opa_i,
  input  logic [sial_pkg::DataW-1:0]      opb_i,
  output sial_pkg::unit_stat_t            stat_o,
  output logic [sial_pkg::DataW-1:0]      hi_o,
  output logic [sial_pkg::DataW-1:0]      lo_o
);

  logic                          busy_q, done_q, div_q;
  logic [sial_pkg::StepW-1:0]    cnt_q;
  logic [sial_pkg::DataW-1:0]    hi_q, hi_d, lo_q, lo_d, opb_q;
  logic [sial_pkg::DataW:0]      a_op, b_op, t_mul;
  logic [sial_pkg::DataW+1:0]    sum;

  // One adder serves both: add the multiplicand, or trial-subtract the divisor.
  always_comb begin
    a_op  = div_q ? {hi_q, lo_q[sial_pkg::DataW-1]} : {1'b0, hi_q};
    b_op  = div_q ? ~{1'b0, opb_q} : {1'b0, opb_q};
    sum   = {1'b0, a_op} + {1'b0, b_op} + {{(sial_pkg::DataW+1){1'b0}}, div_q};
    t_mul = lo_q[0] ? sum[sial_pkg::DataW:0] : {1'b0, hi_q};
    if (div_q) begin
      hi_d = sum[sial_pkg::DataW+1] ? sum[sial_pkg::DataW-1:0] : a_op[sial_pkg::DataW-1:0];
      lo_d = {lo_q[sial_pkg::DataW-2:0], sum[sial_pkg::DataW+1]};
    end else begin
      hi_d = t_mul[sial_pkg::DataW:1];
      lo_d = {t_mul[0], lo_q[sial_pkg::DataW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= sial_pkg::StepW'(sial_pkg::Steps - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      div_q <= ctl_i.div;
      hi_q  <= '0;
      lo_q  <= opa_i;
      opb_q <= opb_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign hi_o        = hi_q;
  assign lo_o        = lo_q;

endmodule

// ===== src/saturating_integer_alu_top.sv =====
// Saturating 64-bit integer ALU, top level. Depends on sial_pkg, sial_unit
// and saturating_integer_alu_top_assert.svh.
// Add, sub, compares and logic go from IDLE straight to DONE; mul, div and mod
// take one pass of the shared unit; pow runs its square and multiply steps as
// passes of the shared unit, set by the square-and-multiply sequence.
// One beat in flight at a time; a finished result may wait in the output
// register while the next beat is taken. Reset is asynchronous, active low,
// and clears the sequencer and the output valid.
`include "saturating_integer_alu_top_assert.svh"
module saturating_integer_alu_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sial_pkg::in_beat_t   in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sial_pkg::out_beat_t  out_o
);

  // One-hot sequencer: IDLE takes a beat, CALC waits on the shared unit,
  // the P states run square-and-multiply, DONE hands off to the output.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CALC = 6'b000010,
    S_PHD  = 6'b000100,
    S_PACC = 6'b001000,
    S_PSQR = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  sial_pkg::mode_e               kind_q, kind_d;
  logic                          neg_q, neg_d;
  logic [sial_pkg::DataW-1:0]    acc_q, acc_d, m_q, m_d, expo_q, expo_d;
  sial_pkg::out_beat_t           res_q, res_d, out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  sial_pkg::unit_ctl_t           ctl;
  sial_pkg::unit_stat_t          stat;
  logic [sial_pkg::DataW-1:0]    opa, opb, hi, lo;

  logic [sial_pkg::DataW-1:0]    l_u, r_u, mag_l, mag_r, sum, diff;

  always_comb begin
    l_u   = in_i.left;
    r_u   = in_i.right;
    mag_l = l_u[sial_pkg::DataW-1] ? (~l_u + 1'b1) : l_u;
    mag_r = r_u[sial_pkg::DataW-1] ? (~r_u + 1'b1) : r_u;
    sum   = l_u + r_u;
    diff  = l_u - r_u;
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    m_d         = m_q;
    expo_d      = expo_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ctl         = '0;
    opa         = m_q;
    opb         = m_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d   = '0;
          state_d = S_DONE;
          kind_d  = sial_pkg::mode_e'(in_i.mode);
          unique case (sial_pkg::mode_e'(in_i.mode)) inside
            sial_pkg::OP_ADD: begin
              res_d.value = sum;
              // Overflow when both signs agree and the sum's sign differs.
              if (l_u[63] == r_u[63] && sum[63] != l_u[63]) begin
                res_d.value = l_u[63] ? sial_pkg::SMin : sial_pkg::SMax;
              end
            end
            sial_pkg::OP_SUB: begin
              res_d.value = diff;
              if (l_u[63] != r_u[63] && diff[63] != l_u[63]) begin
                res_d.value = l_u[63] ? sial_pkg::SMin : sial_pkg::SMax;
              end
            end
            sial_pkg::OP_MUL: begin
              ctl.start = 1'b1;
              opa       = mag_l;
              opb       = mag_r;
              neg_d     = l_u[63] ^ r_u[63];
              state_d   = S_CALC;
            end
            sial_pkg::OP_DIV, sial_pkg::OP_MOD: begin
              if (r_u == '0) begin
                res_d.error = 1'b1;
              end else begin
                ctl.start = 1'b1;
                ctl.div   = 1'b1;
                opa       = mag_l;
                opb       = mag_r;
                // The quotient takes both signs, the remainder the dividend's.
                neg_d     = (sial_pkg::mode_e'(in_i.mode) == sial_pkg::OP_DIV) ?
                            (l_u[63] ^ r_u[63]) : l_u[63];
                state_d   = S_CALC;
              end
            end
            sial_pkg::OP_EQ:  res_d.value = {63'd0, l_u == r_u};
            sial_pkg::OP_LT:  res_d.value = {63'd0, in_i.left < in_i.right};
            sial_pkg::OP_GT:  res_d.value = {63'd0, in_i.right < in_i.left};
            sial_pkg::OP_POW: begin
              if (r_u[63]) begin
                res_d.error = 1'b1;
              end else begin
                m_d     = mag_l;
                expo_d  = r_u;
                acc_d   = 64'd1;
                neg_d   = l_u[63] & r_u[0];
                state_d = S_PHD;
              end
            end
            sial_pkg::OP_AND: res_d.value = {63'd0, (l_u != '0) && (r_u != '0)};
            sial_pkg::OP_OR:  res_d.value = {63'd0, (l_u != '0) || (r_u != '0)};
            default:          res_d.error = 1'b1;
          endcase
        end
      end
      S_CALC: begin
        if (stat.done) begin
          state_d = S_DONE;
          if (kind_q == sial_pkg::OP_MUL) begin
            res_d.value = sial_pkg::sat_clamp(hi != '0, lo, neg_q);
          end else if (kind_q == sial_pkg::OP_DIV) begin
            res_d.value = sial_pkg::sat_clamp(1'b0, lo, neg_q);
          end else begin
            res_d.value = sial_pkg::sat_clamp(1'b0, hi, neg_q);
          end
        end
      end
      S_PHD: begin
        if (expo_q == '0) begin
          res_d.value = sial_pkg::sat_clamp(1'b0, acc_q, neg_q);
          state_d     = S_DONE;
        end else if (m_q[63:1] == '0) begin
          // A base of one leaves the product alone; zero clears it.
          acc_d  = m_q[0] ? acc_q : '0;
          expo_d = '0;
        end else if (m_q == sial_pkg::PowCap || acc_q == sial_pkg::PowCap) begin
          // Once capped, every later factor keeps the result at the cap.
          acc_d  = sial_pkg::PowCap;
          expo_d = '0;
        end else if (expo_q[0]) begin
          ctl.start = 1'b1;
          opa       = acc_q;
          opb       = m_q;
          state_d   = S_PACC;
        end else begin
          ctl.start = 1'b1;
          expo_d    = expo_q >> 1;
          state_d   = S_PSQR;
        end
      end
      S_PACC: begin
        if (stat.done) begin
          acc_d     = sial_pkg::cap_prod(hi, lo);
          expo_d[0] = 1'b0;
          state_d   = S_PHD;
        end
      end
      S_PSQR: begin
        if (stat.done) begin
          m_d     = sial_pkg::cap_prod(hi, lo);
          state_d = S_PHD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    neg_q  <= neg_d;
    acc_q  <= acc_d;
    m_q    <= m_d;
    expo_q <= expo_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  sial_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .opa_i  (opa),
    .opb_i  (opb),
    .stat_o (stat),
    .hi_o   (hi),
    .lo_o   (lo)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // An error result always carries a zero value.
  `SIAL_ASSERT_IMP(a_err_zero, out_valid_q && out_q.error, out_q.value == '0, "error with value")
  // The shared unit is never restarted while it is still stepping.
  `SIAL_ASSERT_IMP(a_unit_free, ctl.start, !stat.busy, "unit restarted while busy")
  // A result leaving DONE shows up as a valid output beat.
  `SIAL_ASSERT_NXT(a_done_out, state_q == S_DONE && state_d == S_IDLE, out_valid_q,
                   "result lost")
  // An accepted beat always moves the sequencer out of idle.
  `SIAL_ASSERT_NXT(a_take, in_valid_i && !in_stall_o, state_q != S_IDLE, "beat ignored")

endmodule
